FILE: hdl/bsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_pkg: shared types and constants of the bencode stream parser
// Character codes, event and error codes, parser state and result records.
// ----------------------------------------------------------------------------
package bsp_pkg;

    // Sizing
    localparam int MAX_DEPTH   = 32;
    localparam int OFFSET_BITS = 32;
    localparam int SP_BITS     = $clog2(MAX_DEPTH + 1);
    localparam int RAM_DEPTH   = (MAX_DEPTH > 2) ? MAX_DEPTH - 1 : 2;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);
    localparam int FRAME_BITS  = 2 + OFFSET_BITS;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;

    // Character codes
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Integer flag bit positions
    localparam int FLAG_SIGN  = 0;
    localparam int FLAG_DIGIT = 1;
    localparam int FLAG_ZERO  = 2;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_INT  = 2'd1,
        MODE_LEN  = 2'd2,
        MODE_BODY = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_LIST = 2'd1,
        KIND_DKEY = 2'd2,
        KIND_DVAL = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        EV_INSIDE     = 3'd0,
        EV_INT_DONE   = 3'd1,
        EV_STR_DONE   = 3'd2,
        EV_LIST_OPEN  = 3'd3,
        EV_DICT_OPEN  = 3'd4,
        EV_LIST_CLOSE = 3'd5,
        EV_DICT_CLOSE = 3'd6,
        EV_ERROR      = 3'd7
    } t_event;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_UNEXP_END  = 4'd1,
        ERR_BAD_INT    = 4'd2,
        ERR_BAD_LEN    = 4'd3,
        ERR_OUT_BOUND  = 4'd4,
        ERR_BAD_CHAR   = 4'd5,
        ERR_LIST_OPEN  = 4'd6,
        ERR_DICT_OPEN  = 4'd7,
        ERR_KEY_TYPE   = 4'd8,
        ERR_NEST_OVER  = 4'd9
    } t_err;

    // Container frame kept below the top of stack
    typedef struct packed {
        t_kind                  kind;
        logic [OFFSET_BITS-1:0] start;
    } t_frame;

    // Architectural parser state; the top container lives in registers
    typedef struct packed {
        t_mode                  mode;
        logic [SP_BITS-1:0]     sp;
        logic [31:0]            rem;
        logic [2:0]             flags;
        logic [OFFSET_BITS-1:0] off;
        t_err                   err;
        t_kind                  top_kind;
        logic [OFFSET_BITS-1:0] top_start;
        logic [OFFSET_BITS-1:0] scal_start;
    } t_state;

    // Frame store write request
    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] addr;
        t_frame            data;
    } t_frame_wr;

    // One result beat
    typedef struct packed {
        t_event      ev;
        logic [5:0]  nest;
        logic [31:0] elem_start;
        logic [31:0] elem_end;
        t_err        err;
        logic        done;
    } t_result;

    localparam t_state STATE_RESET = '{
        mode:       MODE_IDLE,
        sp:         '0,
        rem:        '0,
        flags:      '0,
        off:        '0,
        err:        ERR_NONE,
        top_kind:   KIND_NONE,
        top_start:  '0,
        scal_start: '0
    };

endpackage
`default_nettype wire

FILE: hdl/bsp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data (old data on
// a same-address collision).
// ----------------------------------------------------------------------------
module bsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: hdl/bsp_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bsp_step: per-byte parse step
// Combinational next state, frame store write and result for one byte.
// ----------------------------------------------------------------------------
module bsp_step import bsp_pkg::*; (
    input  wire t_state     i_state,
    input  wire t_frame     i_below,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last_byte,
    output t_state          o_state,
    output t_frame_wr       o_wr,
    output t_result         o_result
);

    t_state                 n;
    t_err                   err;
    t_event                 ev;
    logic [OFFSET_BITS-1:0] es;
    logic [OFFSET_BITS-1:0] ee;
    logic [OFFSET_BITS-1:0] off_next;
    logic                   finished;
    logic                   popped;
    logic                   is_digit;
    logic                   is_open;
    logic [3:0]             digit;
    logic [35:0]            len_next;
    logic [SP_BITS-1:0]     sp_m1;

    function automatic t_kind flip(t_kind k);
        unique case (k)
            KIND_DKEY: flip = KIND_DVAL;
            KIND_DVAL: flip = KIND_DKEY;
            default:   flip = k;
        endcase
    endfunction

    assign is_digit = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
    assign is_open  = (i_data_byte == CH_L) || (i_data_byte == CH_D);
    assign digit    = 4'(i_data_byte - CH_ZERO);
    assign sp_m1    = i_state.sp - SP_BITS'(1);
    assign off_next = (i_state.off == OFF_MAX) ? i_state.off
                                               : i_state.off + OFFSET_BITS'(1);
    // rem * 10 + digit, wide enough to see overflow past 32 bits
    assign len_next = ({4'b0, i_state.rem} << 3) + ({4'b0, i_state.rem} << 1)
                    + {32'b0, digit};

    always_comb begin
        n        = i_state;
        err      = i_state.err;
        ev       = EV_INSIDE;
        es       = '0;
        ee       = '0;
        finished = 1'b0;
        popped   = 1'b0;
        o_wr.we   = 1'b0;
        o_wr.addr = sp_m1[RAM_AW-1:0];
        o_wr.data = '{kind: i_state.top_kind, start: i_state.top_start};

        // Byte decode
        if (i_state.err == ERR_NONE) begin
            unique case (i_state.mode)
                MODE_IDLE: begin
                    priority if (i_data_byte == CH_E &&
                                 (i_state.top_kind == KIND_LIST ||
                                  i_state.top_kind == KIND_DKEY)) begin
                        popped   = 1'b1;
                        n.sp     = sp_m1;
                        es       = i_state.top_start;
                        ev       = (i_state.top_kind == KIND_LIST) ? EV_LIST_CLOSE
                                                                    : EV_DICT_CLOSE;
                        finished = 1'b1;
                    end else if (i_state.top_kind == KIND_DKEY &&
                                 (i_data_byte == CH_I || is_open)) begin
                        err = ERR_KEY_TYPE;
                    end else if (i_data_byte == CH_I) begin
                        n.scal_start = i_state.off;
                        n.flags      = '0;
                        n.mode       = MODE_INT;
                    end else if (is_open) begin
                        if (i_state.sp >= SP_BITS'(MAX_DEPTH)) begin
                            err = ERR_NEST_OVER;
                        end else begin
                            // spill the current top frame, new container on top
                            o_wr.we     = (i_state.sp != '0);
                            n.sp        = i_state.sp + SP_BITS'(1);
                            n.top_kind  = (i_data_byte == CH_L) ? KIND_LIST : KIND_DKEY;
                            n.top_start = i_state.off;
                            ev          = (i_data_byte == CH_L) ? EV_LIST_OPEN
                                                                 : EV_DICT_OPEN;
                        end
                    end else if (is_digit) begin
                        n.scal_start = i_state.off;
                        n.rem        = {28'b0, digit};
                        n.mode       = MODE_LEN;
                    end else begin
                        err = ERR_BAD_CHAR;
                    end
                end
                MODE_INT: begin
                    priority if (i_data_byte == CH_MINUS && i_state.flags == '0) begin
                        n.flags = 3'b001 << FLAG_SIGN;
                    end else if (is_digit) begin
                        priority if (i_state.flags[FLAG_ZERO]) begin
                            err = ERR_BAD_INT;
                        end else if (!i_state.flags[FLAG_DIGIT] &&
                                     i_data_byte == CH_ZERO) begin
                            if (i_state.flags[FLAG_SIGN]) begin
                                err = ERR_BAD_INT;
                            end else begin
                                n.flags[FLAG_ZERO]  = 1'b1;
                                n.flags[FLAG_DIGIT] = 1'b1;
                            end
                        end else begin
                            n.flags[FLAG_DIGIT] = 1'b1;
                        end
                    end else if (i_data_byte == CH_E && i_state.flags[FLAG_DIGIT]) begin
                        es       = i_state.scal_start;
                        ev       = EV_INT_DONE;
                        finished = 1'b1;
                    end else begin
                        err = ERR_BAD_INT;
                    end
                end
                MODE_LEN: begin
                    priority if (is_digit) begin
                        if (len_next[35:32] != 4'b0) begin
                            err = ERR_BAD_LEN;
                        end else begin
                            n.rem = len_next[31:0];
                        end
                    end else if (i_data_byte == CH_COLON) begin
                        priority if (i_state.rem == '0) begin
                            es       = i_state.scal_start;
                            ev       = EV_STR_DONE;
                            finished = 1'b1;
                        end else if (i_last_byte) begin
                            err = ERR_OUT_BOUND;
                        end else begin
                            n.mode = MODE_BODY;
                        end
                    end else begin
                        err = ERR_BAD_CHAR;
                    end
                end
                MODE_BODY: begin
                    if (i_state.rem != '0) begin
                        n.rem = i_state.rem - 32'd1;
                    end
                    if (i_state.rem <= 32'd1) begin
                        es       = i_state.scal_start;
                        ev       = EV_STR_DONE;
                        finished = 1'b1;
                    end
                end
                default: begin
                    err = ERR_BAD_CHAR;
                end
            endcase
        end

        // Element done: back to idle, dictionary toggles key/value
        if (finished) begin
            ee     = off_next;
            n.mode = MODE_IDLE;
            if (popped) begin
                n.top_kind  = (n.sp == '0) ? KIND_NONE : flip(i_below.kind);
                n.top_start = i_below.start;
            end else begin
                n.top_kind = flip(i_state.top_kind);
            end
        end

        // Buffer end checks
        if (err == ERR_NONE && i_last_byte) begin
            unique case (n.mode)
                MODE_INT:  err = ERR_BAD_INT;
                MODE_LEN:  err = ERR_UNEXP_END;
                MODE_BODY: err = ERR_OUT_BOUND;
                default: begin
                    if (n.sp != '0) begin
                        priority if (n.top_kind == KIND_LIST) begin
                            err = ERR_LIST_OPEN;
                        end else if (n.top_kind == KIND_DKEY) begin
                            err = ERR_DICT_OPEN;
                        end else begin
                            err = ERR_UNEXP_END;
                        end
                    end
                end
            endcase
        end

        if (err != ERR_NONE) begin
            ev = EV_ERROR;
            es = '0;
            ee = '0;
        end

        o_result.ev         = ev;
        o_result.nest       = 6'(n.sp);
        o_result.elem_start = 32'(es);
        o_result.elem_end   = 32'(ee);
        o_result.err        = err;
        o_result.done       = i_last_byte && (err == ERR_NONE);

        n.off = off_next;
        n.err = err;
        if (i_last_byte) begin
            n = STATE_RESET;
        end
        o_state = n;
    end

endmodule
`default_nettype wire

FILE: hdl/bencode_stream_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bencode_stream_parser: streaming bencode checker
// Input channel (i_valid/o_ready) takes one buffer byte per beat, with
// i_last_byte on the final byte. Output channel (o_valid/i_ready) gives one
// event beat per input byte, in order: event code, nesting depth, start and
// end offsets of a completed element, latched error code and a clean-done
// flag on the last byte.
// A byte is held in the input register and parsed on the way into the
// result register, from which its event beat is offered on the output
// channel. Throughput: one byte per cycle while i_ready is high; the parse
// step is a single combinational pass, and the frame store (registered
// read) is prefetched at the address below the top of stack, so pops do
// not stall. When i_ready is low the result register holds and the input
// register still takes one more byte; o_ready drops only when both are full.
// Reset: parser state goes idle at offset 0 with an empty stack and no
// error; both registers empty. The frame store needs no clearing. After the
// last byte of a buffer the parser state returns to its reset values.
// ----------------------------------------------------------------------------
module bencode_stream_parser import bsp_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_event_res,
    output logic [5:0]       o_nest_level,
    output logic [31:0]      o_element_start,
    output logic [31:0]      o_element_end,
    output logic [3:0]       o_error_code,
    output logic             o_done_res
);

    logic       r_in_valid;
    logic [7:0] r_in_data;
    logic       r_in_last;
    t_state     r_state;
    t_state     n_state;
    logic       r_out_valid;
    t_result    r_out;
    logic       r_byp;
    t_frame     r_byp_data;

    t_state             step_state;
    t_frame_wr          step_wr;
    t_result            step_result;
    t_frame             ram_rdata;
    t_frame             below;
    logic               advance;
    logic               fire;
    logic [SP_BITS-1:0] rd_sp;

    // Pipeline control
    assign advance = !r_out_valid || i_ready;
    assign fire    = r_in_valid && advance;
    assign o_ready = !r_in_valid || advance;

    // Frame below the top of stack, with bypass of last cycle's spill
    assign below   = r_byp ? r_byp_data : ram_rdata;
    assign n_state = fire ? step_state : r_state;
    assign rd_sp   = n_state.sp - SP_BITS'(2);

    bsp_step u_step (
        .i_state     (r_state),
        .i_below     (below),
        .i_data_byte (r_in_data),
        .i_last_byte (r_in_last),
        .o_state     (step_state),
        .o_wr        (step_wr),
        .o_result    (step_result)
    );

    bsp_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_frames (
        .i_clk   (i_clk),
        .i_we    (fire && step_wr.we),
        .i_waddr (step_wr.addr),
        .i_wdata (step_wr.data),
        .i_raddr (rd_sp[RAM_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
            r_byp       <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            r_state <= n_state;
            r_byp   <= fire && step_wr.we;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (fire) begin
            r_out <= step_result;
        end
        r_byp_data <= step_wr.data;
    end

    assign o_valid         = r_out_valid;
    assign o_event_res     = r_out.ev;
    assign o_nest_level    = r_out.nest;
    assign o_element_start = r_out.elem_start;
    assign o_element_end   = r_out.elem_end;
    assign o_error_code    = r_out.err;
    assign o_done_res      = r_out.done;

endmodule
`default_nettype wire
